>>> src/gcfb_pkg.sv
// Shared types, constants and fixed-point helpers of the GRU gate unit.
// No dependencies; imported by the cache, the top level and the testbench.
package gcfb_pkg;

   localparam int FRAC_BITS = 12;
   localparam int WORD_W    = 24;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type ONE_Q     = word_type'(1 << FRAC_BITS);
   localparam word_type HALF_Q    = word_type'(1 << (FRAC_BITS - 1));
   localparam word_type SIG_SAT_T = word_type'(5 << FRAC_BITS);
   localparam word_type SIG_MID_T = word_type'((19 << FRAC_BITS) >> 3);
   localparam word_type SIG_MID_C = word_type'((27 << FRAC_BITS) >> 5);
   localparam word_type SIG_LOW_C = word_type'((5 << FRAC_BITS) >> 3);
   localparam word_type SAT_MAX   = word_type'(32767);
   localparam word_type SAT_MIN   = -word_type'(32768);

   typedef enum logic {
      CMD_FWD = 1'b0,
      CMD_BWD = 1'b1
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] r;
      logic signed [15:0] n;
   } cache_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               ok;
      logic [7:0]         idx;
      logic signed [15:0] ih_z;
      logic signed [15:0] ih_r;
      logic signed [15:0] ih_n;
      logic signed [15:0] hh_z;
      logic signed [15:0] hh_r;
      logic signed [15:0] hh_n;
      logic signed [15:0] prev_h;
      logic signed [15:0] grad_out;
      word_type           z;
      word_type           r;
      word_type           rh;
      word_type           n;
      logic signed [31:0] pa;
      logic signed [31:0] pb;
      word_type           h;
      word_type           m;
      word_type           a;
      word_type           nn;
      word_type           dp;
      word_type           dn;
      word_type           dz;
      word_type           b;
      word_type           dhh;
      word_type           c;
      word_type           dr;
   } stage_type;

   // Rounded fixed-point product, floor shift after adding one half.
   function automatic word_type qmul(input word_type x, input word_type y);
      logic signed [2*WORD_W-1:0] p;
      p = (2*WORD_W)'(x) * (2*WORD_W)'(y);
      p = p + (2*WORD_W)'(HALF_Q);
      p = p >>> FRAC_BITS;
      return p[WORD_W-1:0];
   endfunction

   // Piecewise-linear sigmoid, mirrored for negative input.
   function automatic word_type sig_q(input word_type x);
      word_type a;
      word_type y;
      a = x[WORD_W-1] ? -x : x;
      if (a >= SIG_SAT_T) begin
         y = ONE_Q;
      end else if (a >= SIG_MID_T) begin
         y = (a >>> 5) + SIG_MID_C;
      end else if (a >= ONE_Q) begin
         y = (a >>> 3) + SIG_LOW_C;
      end else begin
         y = (a >>> 2) + HALF_Q;
      end
      return x[WORD_W-1] ? ONE_Q - y : y;
   endfunction

   function automatic word_type tanh_q(input word_type x);
      return (sig_q(x <<< 1) <<< 1) - ONE_Q;
   endfunction

   function automatic word_type sat_q(input word_type v);
      if (v > SAT_MAX) begin
         return SAT_MAX;
      end else if (v < SAT_MIN) begin
         return SAT_MIN;
      end
      return v;
   endfunction

endpackage

>>> src/gcfb_cache.sv
// Gate cache: one entry of z, r and n per hidden unit, registered read.
// Depends on gcfb_pkg for the entry type.
module gcfb_cache
   import gcfb_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  cache_type     wr_data,
   output cache_type     rd_data
);

   cache_type mem [DEPTH];
   cache_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> src/gru_cell_forward_backward.sv
// GRU element-wise gate unit: ten-stage pipeline for forward and backward items.
// Depends on gcfb_pkg and gcfb_cache.
//
// Usage:
//   req_* carries one item per hidden unit; req_tuser is the command
//   (0 forward, 1 backward). rsp_* returns exactly one result item per
//   request item, in order.
//   Forward: new_h from the six pre-activations and prev_h; z, r, n are
//   stored in the gate cache under unit_index. Backward: reads the cache
//   of unit_index and returns the five gradients.
//   Throughput: one item per cycle while rsp_tready stays high. Ten register
//   stages (gates, r*hh_n, tanh, cache read, then the chain of five
//   dependent products of the reset-gate gradient) lie on the path, the
//   first of which captures the input.
//   Cache access happens as an item leaves the tanh stage, in order, so a
//   backward item always sees every forward item accepted before it.
//   Stall: each stage holds while the one after it is full and stalled;
//   empty stages keep filling, so items are still taken until the pipe
//   is full. Reset clears all valid bits; the cache is not cleared and a
//   backward item for an unwritten unit returns unspecified gradients.
module gru_cell_forward_backward
   import gcfb_pkg::*;
#(
   parameter int MAX_UNITS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // low to high: unit_index, ih_z, ih_r, ih_n, hh_z, hh_r, hh_n, prev_h, grad_out
   input  logic [135:0] req_tdata,
   // cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // low to high: new_h, grad_z_raw, grad_r_raw, grad_n_pre, grad_hh_n, grad_prev
   output logic [95:0]  rsp_tdata
);

   localparam int DEPTH = (MAX_UNITS < 256) ? MAX_UNITS : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NSTG  = 10;

   stage_type        stage_ff [NSTG];
   stage_type        stage_in [NSTG];
   logic [NSTG-1:0]  valid_ff;
   logic [NSTG-1:0]  valid_in;
   logic [NSTG-1:0]  load;
   logic [NSTG:0]    rdy;
   cache_type        rd_data;
   cache_type        wr_data;
   logic             wr_en;

   // Handshake chain: a stage takes an item when empty or when it drains.
   always_comb begin
      rdy[NSTG] = rsp_tready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      load[0] = req_tvalid && rdy[0];
      for (int k = 1; k < NSTG; k++) begin
         load[k] = valid_ff[k-1] && rdy[k];
      end
      for (int k = 0; k < NSTG; k++) begin
         valid_in[k] = load[k] || (valid_ff[k] && !rdy[k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Cache sits between the tanh stage and stage four.
   assign wr_en   = load[4] && (stage_ff[3].cmd == CMD_FWD) && stage_ff[3].ok;
   assign wr_data = '{z: stage_ff[3].z[15:0], r: stage_ff[3].r[15:0],
                      n: stage_ff[3].n[15:0]};

   gcfb_cache #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_cache (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (load[4]),
      .addr    (stage_ff[3].idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      word_type ez;
      word_type er;
      word_type en;
      word_type g;
      logic signed [31:0] hs;
      logic fwd;

      // stage 0: unpack
      stage_in[0]          = '0;
      stage_in[0].cmd      = cmd_type'(req_tuser);
      stage_in[0].idx      = req_tdata[7:0];
      stage_in[0].ok       = (13'(req_tdata[7:0]) < 13'(MAX_UNITS));
      stage_in[0].ih_z     = req_tdata[23:8];
      stage_in[0].ih_r     = req_tdata[39:24];
      stage_in[0].ih_n     = req_tdata[55:40];
      stage_in[0].hh_z     = req_tdata[71:56];
      stage_in[0].hh_r     = req_tdata[87:72];
      stage_in[0].hh_n     = req_tdata[103:88];
      stage_in[0].prev_h   = req_tdata[119:104];
      stage_in[0].grad_out = req_tdata[135:120];

      // stage 1: update and reset gates
      stage_in[1]   = stage_ff[0];
      stage_in[1].z = sig_q(word_type'(stage_ff[0].ih_z) + word_type'(stage_ff[0].hh_z));
      stage_in[1].r = sig_q(word_type'(stage_ff[0].ih_r) + word_type'(stage_ff[0].hh_r));

      // stage 2: r * hh_n
      stage_in[2]    = stage_ff[1];
      stage_in[2].rh = qmul(stage_ff[1].r, word_type'(stage_ff[1].hh_n));

      // stage 3: candidate
      stage_in[3]   = stage_ff[2];
      stage_in[3].n = tanh_q(word_type'(stage_ff[2].ih_n) + stage_ff[2].rh);

      // stage 4: cache read lands beside this stage
      stage_in[4] = stage_ff[3];

      // stage 5: pick gates, first products of both directions
      if (stage_ff[4].cmd == CMD_BWD) begin
         ez = stage_ff[4].ok ? word_type'(rd_data.z) : '0;
         er = stage_ff[4].ok ? word_type'(rd_data.r) : '0;
         en = stage_ff[4].ok ? word_type'(rd_data.n) : '0;
      end else begin
         ez = stage_ff[4].z;
         er = stage_ff[4].r;
         en = stage_ff[4].n;
      end
      g              = word_type'(stage_ff[4].grad_out);
      stage_in[5]    = stage_ff[4];
      stage_in[5].z  = ez;
      stage_in[5].r  = er;
      stage_in[5].n  = en;
      stage_in[5].pa = 32'(ONE_Q - ez) * 32'(en);
      stage_in[5].pb = 32'(ez) * 32'(stage_ff[4].prev_h);
      stage_in[5].m  = qmul(g, word_type'(stage_ff[4].prev_h) - en);
      stage_in[5].a  = qmul(g, ONE_Q - ez);
      stage_in[5].nn = qmul(en, en);
      stage_in[5].dp = qmul(g, ez);

      // stage 6: new state sum, second products
      hs              = (stage_ff[5].pa + stage_ff[5].pb + 32'(HALF_Q)) >>> FRAC_BITS;
      stage_in[6]     = stage_ff[5];
      stage_in[6].h   = hs[WORD_W-1:0];
      stage_in[6].m   = qmul(stage_ff[5].m, stage_ff[5].z);
      stage_in[6].dn  = qmul(stage_ff[5].a, ONE_Q - stage_ff[5].nn);

      // stage 7
      stage_in[7]     = stage_ff[6];
      stage_in[7].dz  = qmul(stage_ff[6].m, ONE_Q - stage_ff[6].z);
      stage_in[7].b   = qmul(stage_ff[6].dn, word_type'(stage_ff[6].hh_n));
      stage_in[7].dhh = qmul(stage_ff[6].dn, stage_ff[6].r);

      // stage 8
      stage_in[8]   = stage_ff[7];
      stage_in[8].c = qmul(stage_ff[7].b, stage_ff[7].r);

      // stage 9: last product, saturate, zero the fields of the other direction
      fwd             = (stage_ff[8].cmd == CMD_FWD);
      stage_in[9]     = stage_ff[8];
      stage_in[9].h   = fwd ? sat_q(stage_ff[8].h) : '0;
      stage_in[9].dz  = fwd ? '0 : sat_q(stage_ff[8].dz);
      stage_in[9].dr  = fwd ? '0 : sat_q(qmul(stage_ff[8].c, ONE_Q - stage_ff[8].r));
      stage_in[9].dn  = fwd ? '0 : sat_q(stage_ff[8].dn);
      stage_in[9].dhh = fwd ? '0 : sat_q(stage_ff[8].dhh);
      stage_in[9].dp  = fwd ? '0 : sat_q(stage_ff[8].dp);
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = valid_ff[NSTG-1];
   assign rsp_tdata  = {stage_ff[NSTG-1].dp[15:0],  stage_ff[NSTG-1].dhh[15:0],
                        stage_ff[NSTG-1].dn[15:0],  stage_ff[NSTG-1].dr[15:0],
                        stage_ff[NSTG-1].dz[15:0],  stage_ff[NSTG-1].h[15:0]};

endmodule

>>> src/gcfb_checker.sv
// Port-level checks of the GRU gate unit, bound to the top level.
// Depends only on the top-level port names.
module gcfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an empty output stage means the whole chain can take an item
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with output stage empty");

   // a result with a nonzero new state carries no gradients
   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] != 16'h0) |-> (rsp_tdata[95:16] == 80'h0))
      else $error("result mixes forward and backward fields");

endmodule

bind gru_cell_forward_backward gcfb_checker u_gcfb_checker (.*);

>>> tb/sv/gru_cell_forward_backward_chk.sv
`timescale 1ns / 100ps
// Checker for the GRU gate unit: watches the request and response streams,
// predicts every result in fixed point and compares field by field. Uses gcfb_pkg.
module gru_cell_forward_backward_chk
   import gcfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic signed [15:0] grad_out;
      logic signed [15:0] prev_h;
      logic signed [15:0] hh_n;
      logic signed [15:0] hh_r;
      logic signed [15:0] hh_z;
      logic signed [15:0] ih_n;
      logic signed [15:0] ih_r;
      logic signed [15:0] ih_z;
      logic [7:0]         idx;
   } gate_req_type;

   typedef struct packed {
      logic signed [15:0] grad_prev;
      logic signed [15:0] grad_hh_n;
      logic signed [15:0] grad_n_pre;
      logic signed [15:0] grad_r_raw;
      logic signed [15:0] grad_z_raw;
      logic signed [15:0] new_h;
   } gate_rsp_type;

   localparam longint UNIT = 64'sd1 << FRAC_BITS;

   longint       upd_gate [256];
   longint       rst_gate [256];
   longint       cand     [256];
   gate_rsp_type rsp_queue [$];

   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (UNIT >>> 1)) >>> FRAC_BITS;
   endfunction

   function automatic longint fx_sig(longint x);
      longint a, y;
      a = x < 0 ? -x : x;
      if (a >= 5 * UNIT) y = UNIT;
      else if (a >= ((19 * UNIT) >>> 3)) y = (a >>> 5) + ((27 * UNIT) >>> 5);
      else if (a >= UNIT) y = (a >>> 3) + ((5 * UNIT) >>> 3);
      else y = (a >>> 2) + (UNIT >>> 1);
      return x < 0 ? UNIT - y : y;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Forward writes the gate cache; backward reads it.
   function automatic gate_rsp_type gate_predict(logic bwd, gate_req_type it);
      gate_rsp_type o;
      longint z, r, n, h, dn;
      o = '0;
      if (bwd == CMD_FWD) begin
         z = fx_sig(longint'(it.ih_z) + longint'(it.hh_z));
         r = fx_sig(longint'(it.ih_r) + longint'(it.hh_r));
         n = 2 * fx_sig(2 * (longint'(it.ih_n) + fx_mul(r, it.hh_n))) - UNIT;
         h = ((UNIT - z) * n + z * longint'(it.prev_h) + (UNIT >>> 1)) >>> FRAC_BITS;
         upd_gate[it.idx] = z;
         rst_gate[it.idx] = r;
         cand[it.idx]     = n;
         o.new_h = clamp16(h);
      end else begin
         z = upd_gate[it.idx];
         r = rst_gate[it.idx];
         n = cand[it.idx];
         dn = fx_mul(fx_mul(it.grad_out, UNIT - z), UNIT - fx_mul(n, n));
         o.grad_z_raw = clamp16(fx_mul(fx_mul(fx_mul(it.grad_out,
                           longint'(it.prev_h) - n), z), UNIT - z));
         o.grad_r_raw = clamp16(fx_mul(fx_mul(fx_mul(dn, it.hh_n), r), UNIT - r));
         o.grad_n_pre = clamp16(dn);
         o.grad_hh_n  = clamp16(fx_mul(dn, r));
         o.grad_prev  = clamp16(fx_mul(it.grad_out, z));
      end
      return o;
   endfunction

   task automatic cmp_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      gate_rsp_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            rsp_queue.push_back(gate_predict(req_tuser, gate_req_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = gate_rsp_type'(rsp_tdata);
            if (rsp_queue.size() == 0) begin
               $error("result item with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = rsp_queue.pop_front();
               cmp_field("new_h", want.new_h, got.new_h);
               cmp_field("grad_z_raw", want.grad_z_raw, got.grad_z_raw);
               cmp_field("grad_r_raw", want.grad_r_raw, got.grad_r_raw);
               cmp_field("grad_n_pre", want.grad_n_pre, got.grad_n_pre);
               cmp_field("grad_hh_n", want.grad_hh_n, got.grad_hh_n);
               cmp_field("grad_prev", want.grad_prev, got.grad_prev);
            end
         end
      end
      pending <= rsp_queue.size();
   end

endmodule

>>> tb/sv/gru_cell_forward_backward_tb.sv
`timescale 1ns / 100ps
// Top of the GRU gate unit testbench: clock, reset, stimulus and verdict.
// Depends on gcfb_pkg, the block and gru_cell_forward_backward_chk.
module gru_cell_forward_backward_tb;
   import gcfb_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;   // low to high: unit_index, ih_z, ih_r, ih_n, hh_z, hh_r, hh_n, prev_h, grad_out
   logic         req_tuser;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // low to high: new_h, grad_z_raw, grad_r_raw, grad_n_pre, grad_hh_n, grad_prev
   int           fail_count;
   int           pending;

   logic         calm;        // no idling on either side
   logic         hold_rsp;    // request a long receiver hold-off
   logic [255:0] unit_written;
   int           idle_cycles;

   gru_cell_forward_backward uut (.*);

   gru_cell_forward_backward_chk checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int held;
      rsp_tready = 1'b0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && held < HOLD_CYCLES) begin
            held++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 25);
         end
      end
   end

   // Watchdog on cycles with no item accepted anywhere.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [15:0] pick_q();
      case ($urandom_range(3))
         0: return 16'($urandom);                              // full range
         1: return 16'($signed($urandom_range(49152)) - 24576); // around breakpoints
         2: return 16'($signed($urandom_range(8192)) - 4096);
         default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      endcase
   endfunction

   task automatic send_item(cmd_type cmd, logic [7:0] idx, logic [15:0] ihz, logic [15:0] ihr,
                            logic [15:0] ihn, logic [15:0] hhz, logic [15:0] hhr,
                            logic [15:0] hhn, logic [15:0] prv, logic [15:0] grd);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {grd, prv, hhn, hhr, hhz, ihn, ihr, ihz, idx};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_FWD) unit_written[idx] = 1'b1;
      if (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic rand_item();
      cmd_type    cmd;
      logic [7:0] idx;
      idx = 8'($urandom);
      cmd = ($urandom_range(1) && unit_written[idx]) ? CMD_BWD : CMD_FWD;
      send_item(cmd, idx, pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
                pick_q(), pick_q());
   endtask

   initial begin
      logic [15:0] brk [8];
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_FWD;
      calm         = 1'b0;
      hold_rsp     = 1'b0;
      unit_written = '0;
      idle_cycles  = 0;
      // sigmoid breakpoints 5, 2.375, 1 and their negatives
      brk = '{16'd20480, 16'd9728, 16'd4096, 16'd4095, -16'sd20480, -16'sd9728,
              -16'sd4096, 16'd0};
      @(negedge reset);
      @(posedge clock);

      // directed: extremes and breakpoints, then backward on the same units
      send_item(CMD_FWD, 8'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h7fff, 16'h7fff);
      send_item(CMD_FWD, 8'd255, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000);
      for (int i = 0; i < 8; i++)
         send_item(CMD_FWD, 8'(i + 1), brk[i], 16'd0, brk[i], 16'd0, brk[i], 16'h7fff,
                   16'h8000, 16'd0);
      send_item(CMD_FWD, 8'd9, 16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'h8000,
                16'h7fff, 16'hffff);
      send_item(CMD_BWD, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h7fff);
      send_item(CMD_BWD, 8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000,
                16'h7fff, 16'h8000);
      for (int i = 1; i < 10; i++)
         send_item(CMD_BWD, 8'(i), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
                   pick_q(), pick_q(), 16'h7fff);

      // random, with a sender pause, a calm stretch and a receiver hold-off
      for (int n = 0; n < 1680; n++) begin
         if (n == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (n == 500) calm = 1'b1;
         if (n == 800) calm = 1'b0;
         if (n == 1000) hold_rsp <= 1'b1;
         rand_item();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
